[sv/tlbd_pkg.sv]
// ----------------------------------------------------------------------------
// tlbd_pkg
// Types and constants shared by the three-level button debouncer.
// ----------------------------------------------------------------------------
package tlbd_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int CHAN_W     = 3;
  localparam int PCOUNT_W   = 5;
  localparam int CCOUNT_W   = 7;
  localparam int REPORT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // reset values of the configuration registers
  localparam logic [SAMPLE_W-1:0] RELEASE_THR_RST   = 12'd2100;
  localparam logic [SAMPLE_W-1:0] PRESS_THR_RST     = 12'd1000;
  localparam logic [PCOUNT_W-1:0] PRESS_LIMIT_RST   = 5'd25;
  localparam logic [CCOUNT_W-1:0] CONNECT_LIMIT_RST = 7'd100;

  typedef enum logic [1:0] {
    ST_UNDEFINED     = 2'd0,
    ST_NOT_PRESSED   = 2'd1,
    ST_PRESSED       = 2'd2,
    ST_NOT_CONNECTED = 2'd3
  } line_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RELEASE_THR   = 2'd0,
    REG_PRESS_THR     = 2'd1,
    REG_PRESS_LIMIT   = 2'd2,
    REG_CONNECT_LIMIT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_ACK    = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] release_thr;
    logic [SAMPLE_W-1:0] press_thr;
    logic [PCOUNT_W-1:0] press_limit;
    logic [CCOUNT_W-1:0] connect_limit;
  } cfg_t;

  // per-channel counters kept in the counter memory
  typedef struct packed {
    logic [PCOUNT_W-1:0] press_count;
    logic [CCOUNT_W-1:0] connect_count;
  } cnt_t;

  // result of one read-modify-write of a channel
  typedef struct packed {
    cnt_t        cnt;
    line_state_t state;
    logic        press_evt;
  } upd_t;

endpackage

[sv/tlbd_if.sv]
// ----------------------------------------------------------------------------
// tlbd_if
// Handshake channels of the debouncer: sample items, results, config writes.
// ----------------------------------------------------------------------------
interface tlbd_item_if;
  import tlbd_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [CHAN_W-1:0]   channel;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, kind, channel, sample, input ready);
  modport sink   (input valid, kind, channel, sample, output ready);
endinterface

interface tlbd_result_if;
  import tlbd_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          line_state;
  logic                press_event;
  logic [REPORT_W-1:0] report;
  modport source (output valid, line_state, press_event, report, input ready);
  modport sink   (input valid, line_state, press_event, report, output ready);
endinterface

interface tlbd_cfg_if;
  import tlbd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/tlbd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tlbd_cfg_regs
// Threshold and limit registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module tlbd_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  tlbd_cfg_if.sink        cfg,
  output tlbd_pkg::cfg_t  regs
);
  import tlbd_pkg::*;

  // no write is taken while reset holds the registers
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.release_thr   <= RELEASE_THR_RST;
      regs.press_thr     <= PRESS_THR_RST;
      regs.press_limit   <= PRESS_LIMIT_RST;
      regs.connect_limit <= CONNECT_LIMIT_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_RELEASE_THR:   regs.release_thr   <= cfg.data[SAMPLE_W-1:0];
        REG_PRESS_THR:     regs.press_thr     <= cfg.data[SAMPLE_W-1:0];
        REG_PRESS_LIMIT:   regs.press_limit   <= cfg.data[PCOUNT_W-1:0];
        REG_CONNECT_LIMIT: regs.connect_limit <= cfg.data[CCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[sv/tlbd_count_mem.sv]
// ----------------------------------------------------------------------------
// tlbd_count_mem
// Per-channel counter memory, one write and one registered read port.
// Entries not yet written read as zero.
// ----------------------------------------------------------------------------
module tlbd_count_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output tlbd_pkg::cnt_t rd_data,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  tlbd_pkg::cnt_t wr_data
);
  import tlbd_pkg::*;

  cnt_t             mem [DEPTH];
  logic [DEPTH-1:0] written;
  cnt_t             rd_q;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

[sv/tlbd_update.sv]
// ----------------------------------------------------------------------------
// tlbd_update
// Band decision and saturating counter update for one channel.
// ----------------------------------------------------------------------------
module tlbd_update (
  input  tlbd_pkg::cfg_t                  regs,
  input  logic [tlbd_pkg::SAMPLE_W-1:0]   sample,
  input  tlbd_pkg::cnt_t                  cnt,
  input  tlbd_pkg::line_state_t           state,
  output tlbd_pkg::upd_t                  upd
);
  import tlbd_pkg::*;

  logic [PCOUNT_W-1:0] pc;
  logic [CCOUNT_W-1:0] cc;

  always_comb begin
    pc            = cnt.press_count;
    cc            = cnt.connect_count;
    upd.cnt       = cnt;
    upd.state     = state;
    upd.press_evt = 1'b0;
    if (sample > regs.release_thr) begin
      // released band
      upd.cnt.connect_count = '0;
      upd.cnt.press_count   = (pc != '0) ? pc - PCOUNT_W'(1) : '0;
      if (upd.cnt.press_count == '0) begin
        upd.state = ST_NOT_PRESSED;
      end
    end else if (sample > regs.press_thr) begin
      // mid band, line looks open
      upd.cnt.connect_count = (cc < regs.connect_limit) ? cc + CCOUNT_W'(1)
                                                        : regs.connect_limit;
      if (upd.cnt.connect_count == regs.connect_limit) begin
        upd.state = ST_NOT_CONNECTED;
      end
    end else begin
      // pressed band
      upd.cnt.press_count = (pc < regs.press_limit) ? pc + PCOUNT_W'(1)
                                                    : regs.press_limit;
      if (upd.cnt.press_count == regs.press_limit && state != ST_PRESSED) begin
        upd.state     = ST_PRESSED;
        upd.press_evt = 1'b1;
      end
    end
  end

endmodule

[sv/three_level_button_debouncer.sv]
// ----------------------------------------------------------------------------
// three_level_button_debouncer
// Multichannel analog button qualifier with press latches and packed report.
// ----------------------------------------------------------------------------
// path: an accepted item waits in stage 1 for its counter read, then its
//   result is registered in the output register and offered as a transaction
// throughput: one transaction per cycle if not stalled, set by the single
//   counter memory read port (read at accept, write back with forwarding)
// reset: synchronous; counters read as zero, states undefined, latches clear,
//   registers back to their defaults; no clearing pass, items taken at once
module three_level_button_debouncer #(
  parameter int CHANNELS = 8
) (
  input  logic          clk,
  input  logic          rst,
  tlbd_item_if.sink     item,
  tlbd_result_if.source result,
  tlbd_cfg_if.sink      cfg
);
  import tlbd_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W + 1)'(CHANNELS);

  cfg_t regs;

  // stage 1: item waiting for its counter read
  logic                s1_valid;
  logic                s1_kind;
  logic [CHAN_W-1:0]   s1_channel;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_adv;
  logic                s1_in_range;
  logic [AW-1:0]       s1_addr;

  // last counter write, kept for forwarding
  logic                last_wr_valid;
  logic [AW-1:0]       last_wr_addr;
  cnt_t                last_wr_data;

  cnt_t                mem_rd;
  cnt_t                cnt_cur;
  upd_t                upd;
  logic                wr_en;
  logic                accept;

  // per-channel state and latches, read all at once for the report
  line_state_t         btn_state      [CHANNELS];
  line_state_t         btn_state_next [CHANNELS];
  line_state_t         cur_state;
  logic [CHANNELS-1:0] latch;
  logic [CHANNELS-1:0] latch_next;

  // output register
  logic                out_valid;
  logic [1:0]          out_line_state;
  logic                out_press_event;
  logic [REPORT_W-1:0] out_report;
  logic [REPORT_W-1:0] report_next;
  line_state_t         line_next;

  tlbd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // ---------------------------------------------------------------- accept
  // nothing is taken while reset is high
  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign item.ready = !rst && (!s1_valid || s1_adv);
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind    <= item.kind;
      s1_channel <= item.channel;
      s1_sample  <= item.sample;
    end
  end

  assign s1_addr     = s1_channel[AW-1:0];
  assign s1_in_range = {1'b0, s1_channel} < CH_LIMIT;

  // ------------------------------------------------------- counter memory
  // read issued at accept, data lands with the item in stage 1
  tlbd_count_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (item.channel[AW-1:0]),
    .rd_data (mem_rd),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (upd.cnt)
  );

  // the most recent write always holds the freshest copy of its entry
  assign cnt_cur = (last_wr_valid && last_wr_addr == s1_addr) ? last_wr_data : mem_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_wr_valid <= 1'b0;
    end else if (wr_en) begin
      last_wr_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_wr_addr <= s1_addr;
      last_wr_data <= upd.cnt;
    end
  end

  // ----------------------------------------------------------- update
  assign cur_state = s1_in_range ? btn_state[s1_addr] : ST_UNDEFINED;

  tlbd_update u_upd (
    .regs   (regs),
    .sample (s1_sample),
    .cnt    (cnt_cur),
    .state  (cur_state),
    .upd    (upd)
  );

  assign wr_en = s1_adv && (s1_kind == KIND_SAMPLE) && s1_in_range;

  always_comb begin
    btn_state_next = btn_state;
    latch_next     = latch;
    if (s1_kind == KIND_ACK) begin
      // acknowledge clears every latch
      latch_next = '0;
    end else if (s1_in_range) begin
      btn_state_next[s1_addr] = upd.state;
      if (upd.press_evt) begin
        latch_next[s1_addr] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        btn_state[i] <= ST_UNDEFINED;
      end
      latch <= '0;
    end else if (s1_adv) begin
      btn_state <= btn_state_next;
      latch     <= latch_next;
    end
  end

  // report and addressed-line state, taken after this transaction's update
  always_comb begin
    report_next = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      report_next[2*i +: 2] = latch_next[i] ? ST_PRESSED : btn_state_next[i];
    end
  end

  assign line_next = s1_in_range ? btn_state_next[s1_addr] : ST_UNDEFINED;

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_line_state  <= line_next;
      out_press_event <= (s1_kind == KIND_SAMPLE) && s1_in_range && upd.press_evt;
      out_report      <= report_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.line_state  = out_line_state;
  assign result.press_event = out_press_event;
  assign result.report      = out_report;

  // ---------------------------------------------------------- assertions
  a_evt_is_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_press_event |-> out_line_state == ST_PRESSED)
    else $error("press event reported without pressed state");

  a_evt_sets_latch: assert property (@(posedge clk) disable iff (rst)
    wr_en && upd.press_evt |=> latch[$past(s1_addr)])
    else $error("press event did not set the latch");

  a_ack_clears: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_kind == KIND_ACK |=> latch == '0)
    else $error("acknowledge left a latch set");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !s1_valid && !out_valid && !last_wr_valid)
    else $error("pipeline not empty after reset");

endmodule
